[rtl/traffic_light_sequencer_core_assert.svh]
// ----------------------------------------------------------------------------
// traffic light sequencer assertion macros
// Concurrent checks on clk_i, quiet while rst_ni is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LIGHT_SEQUENCER_CORE_ASSERT_SVH
`define TRAFFIC_LIGHT_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TLS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("traffic light sequencer check failed");
// next-cycle implication
`define TLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("traffic light sequencer check failed");
`else
`define TLS_ASSERT_NOW(lbl, ante, cons)
`define TLS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/tls_pkg.sv]
// ----------------------------------------------------------------------------
// tls_pkg
// Shared types, register indexes, lamp patterns and helpers of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tls_pkg;

  localparam int unsigned CNT_W    = 7;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned LAMP_W   = 6;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_START      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_AMBER_AT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_START     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_AMBER_AT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_START     = 3'd5;

  // register reset values
  localparam logic [TICK_W-1:0] RST_TICKS_PER_COUNT = 8'd51;
  localparam logic [CNT_W-1:0]  RST_FIRST_START     = 7'd23;
  localparam logic [CNT_W-1:0]  RST_FIRST_AMBER_AT  = 7'd20;
  localparam logic [CNT_W-1:0]  RST_SECOND_START    = 7'd15;
  localparam logic [CNT_W-1:0]  RST_SECOND_AMBER_AT = 7'd12;
  localparam logic [CNT_W-1:0]  RST_MANUAL_START    = 7'd3;

  // lamp patterns
  localparam logic [LAMP_W-1:0] PAT_GREEN1 = 6'b010001;
  localparam logic [LAMP_W-1:0] PAT_AMBER1 = 6'b100001;
  localparam logic [LAMP_W-1:0] PAT_GREEN2 = 6'b001010;
  localparam logic [LAMP_W-1:0] PAT_AMBER2 = 6'b001100;

  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd99;

  // manual sequence steps
  localparam logic [1:0] MSTEP_COUNT1 = 2'd0;
  localparam logic [1:0] MSTEP_WAIT1  = 2'd1;
  localparam logic [1:0] MSTEP_COUNT2 = 2'd2;

  typedef struct packed {
    logic [TICK_W-1:0] ticks_per_count;
    logic [CNT_W-1:0]  first_start;
    logic [CNT_W-1:0]  first_amber_at;
    logic [CNT_W-1:0]  second_start;
    logic [CNT_W-1:0]  second_amber_at;
    logic [CNT_W-1:0]  manual_start;
  } tls_cfg_t;

  // one result before the digit split
  typedef struct packed {
    logic [LAMP_W-1:0] lamps;
    logic [CNT_W-1:0]  count;
    logic              display_on;
    logic              manual_active;
  } tls_res_t;

  function automatic logic [CNT_W-1:0] cap99(input logic [CNT_W-1:0] v);
    return (v > COUNT_MAX) ? COUNT_MAX : v;
  endfunction

  // tens of a count up to 99 by reciprocal multiply
  function automatic logic [DIGIT_W-1:0] tens_of(input logic [CNT_W-1:0] c);
    logic [14:0] prod;
    prod = {8'd0, c} * 15'd205;
    return prod[14:11];
  endfunction

endpackage

`default_nettype wire

[rtl/tls_if.sv]
// ----------------------------------------------------------------------------
// tls channel interfaces
// Valid/ready channels for tick words in and display words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tls_in_if;
  logic valid;
  logic ready;
  logic mode_toggle;
  logic advance_button;
  modport source(output valid, output mode_toggle, output advance_button, input ready);
  modport sink(input valid, input mode_toggle, input advance_button, output ready);
endinterface

interface tls_out_if;
  logic                          valid;
  logic                          ready;
  logic [tls_pkg::LAMP_W-1:0]    lamps;
  logic [tls_pkg::DIGIT_W-1:0]   tens_digit;
  logic [tls_pkg::DIGIT_W-1:0]   units_digit;
  logic                          display_on;
  logic                          manual_active;
  modport source(output valid, output lamps, output tens_digit, output units_digit,
                 output display_on, output manual_active, input ready);
  modport sink(input valid, input lamps, input tens_digit, input units_digit,
               input display_on, input manual_active, output ready);
endinterface

`default_nettype wire

[rtl/traffic_light_sequencer_core.sv]
// ----------------------------------------------------------------------------
// traffic light sequencer core
// Two-phase traffic light with manual override, one display word per tick.
//
//   channel  dir  carries
//   in_i     in   mode_toggle, advance_button (one refresh tick)
//   out_o    out  lamps, tens_digit, units_digit, display_on, manual_active
//   cfg      in   cfg_we_i / cfg_idx_i / cfg_data_i register writes
//
// One tick word per clock while out_o is not stalled; an accepted word waits
// in the input register until the result register loads the step result.
// Reset loads the default timing registers and the first auto phase.
// A stalled out_o holds its word; the input register still takes one more.
// ----------------------------------------------------------------------------
`default_nettype none

`include "traffic_light_sequencer_core_assert.svh"

module traffic_light_sequencer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tls_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tls_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  tls_in_if.sink                           in_i,
  tls_out_if.source                        out_o
);
  import tls_pkg::*;

  tls_cfg_t cfg_q;
  tls_res_t res;
  logic     s1_valid, s1_toggle, s1_button;
  logic     advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_count <= RST_TICKS_PER_COUNT;
      cfg_q.first_start     <= RST_FIRST_START;
      cfg_q.first_amber_at  <= RST_FIRST_AMBER_AT;
      cfg_q.second_start    <= RST_SECOND_START;
      cfg_q.second_amber_at <= RST_SECOND_AMBER_AT;
      cfg_q.manual_start    <= RST_MANUAL_START;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TICKS_PER_COUNT: cfg_q.ticks_per_count <= cfg_data_i;
        CFG_FIRST_START:     cfg_q.first_start     <= cfg_data_i[CNT_W-1:0];
        CFG_FIRST_AMBER_AT:  cfg_q.first_amber_at  <= cfg_data_i[CNT_W-1:0];
        CFG_SECOND_START:    cfg_q.second_start    <= cfg_data_i[CNT_W-1:0];
        CFG_SECOND_AMBER_AT: cfg_q.second_amber_at <= cfg_data_i[CNT_W-1:0];
        CFG_MANUAL_START:    cfg_q.manual_start    <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // tick word moves on when the result register is free or draining
  assign advance = s1_valid && (!out_o.valid || out_o.ready);

  tls_in_stage u_in_stage (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .in_ready_o       (in_i.ready),
    .mode_toggle_i    (in_i.mode_toggle),
    .advance_button_i (in_i.advance_button),
    .advance_i        (advance),
    .valid_o          (s1_valid),
    .mode_toggle_o    (s1_toggle),
    .advance_button_o (s1_button)
  );

  tls_step u_step (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .mode_toggle_i    (s1_toggle),
    .advance_button_i (s1_button),
    .cfg_i            (cfg_q),
    .res_o            (res)
  );

  tls_out_stage u_out_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance),
    .res_i           (res),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .lamps_o         (out_o.lamps),
    .tens_o          (out_o.tens_digit),
    .units_o         (out_o.units_digit),
    .display_on_o    (out_o.display_on),
    .manual_active_o (out_o.manual_active)
  );

  // checks
  `TLS_ASSERT_NEXT(a_step_lands, advance, out_o.valid)
  `TLS_ASSERT_NOW(a_blank_digits, out_o.valid && !out_o.display_on, out_o.tens_digit == 4'd0 && out_o.units_digit == 4'd0)
  `TLS_ASSERT_NOW(a_auto_shows, out_o.valid && !out_o.manual_active, out_o.display_on)
  `TLS_ASSERT_NOW(a_digit_range, out_o.valid, out_o.tens_digit <= 4'd9 && out_o.units_digit <= 4'd9)

endmodule

`default_nettype wire

[rtl/tls_in_stage.sv]
// ----------------------------------------------------------------------------
// tls input stage
// Holds one tick word until the step logic consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_in_stage (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic mode_toggle_i,
  input  logic advance_button_i,
  input  logic advance_i,
  output logic valid_o,
  output logic mode_toggle_o,
  output logic advance_button_o
);
  logic valid_q, valid_d;
  logic toggle_q, button_q;
  logic fire;

  // free when empty or draining this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (fire) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (fire) begin
      toggle_q <= mode_toggle_i;
      button_q <= advance_button_i;
    end
  end

  assign valid_o          = valid_q;
  assign mode_toggle_o    = toggle_q;
  assign advance_button_o = button_q;

endmodule

`default_nettype wire

[rtl/tls_step.sv]
// ----------------------------------------------------------------------------
// tls step logic
// Sequencer state and its one-tick update for auto and manual mode.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic              mode_toggle_i,
  input  logic              advance_button_i,
  input  tls_pkg::tls_cfg_t cfg_i,
  output tls_pkg::tls_res_t res_o
);
  import tls_pkg::*;

  logic              manual_q, manual_d;
  logic              phase_q, phase_d;
  logic [CNT_W-1:0]  acount_q, acount_d;
  logic [TICK_W-1:0] atick_q, atick_d;
  logic [LAMP_W-1:0] lamp_q, lamp_d;
  logic [1:0]        mstep_q, mstep_d;
  logic [CNT_W-1:0]  mcount_q, mcount_d;
  logic [TICK_W-1:0] mtick_q, mtick_d;
  logic [TICK_W-1:0] limit;
  logic [TICK_W:0]   t;
  logic [CNT_W-1:0]  amber;

  assign limit = (cfg_i.ticks_per_count == '0) ? TICK_W'(1) : cfg_i.ticks_per_count;

  // next state and result for one tick
  always_comb begin
    manual_d = manual_q;
    phase_d  = phase_q;
    acount_d = acount_q;
    atick_d  = atick_q;
    lamp_d   = lamp_q;
    mstep_d  = mstep_q;
    mcount_d = mcount_q;
    mtick_d  = mtick_q;
    res_o    = '0;
    t        = '0;
    amber    = '0;

    // mode toggle, entering manual restarts it
    if (mode_toggle_i) begin
      manual_d = !manual_q;
      if (!manual_q) begin
        mstep_d  = MSTEP_COUNT1;
        mcount_d = cap99(cfg_i.manual_start);
        mtick_d  = '0;
        lamp_d   = PAT_GREEN1;
      end
    end

    if (!manual_d) begin
      // auto countdown
      amber = phase_q ? cfg_i.second_amber_at : cfg_i.first_amber_at;
      if (atick_q == '0 && acount_q == amber) begin
        lamp_d = phase_q ? PAT_AMBER2 : PAT_AMBER1;
      end
      res_o.lamps      = lamp_d;
      res_o.count      = acount_q;
      res_o.display_on = 1'b1;
      t = {1'b0, atick_q} + (TICK_W+1)'(1);
      if (t >= {1'b0, limit}) begin
        atick_d = '0;
        if (acount_q == '0) begin
          phase_d  = !phase_q;
          acount_d = cap99(phase_q ? cfg_i.first_start : cfg_i.second_start);
          lamp_d   = phase_q ? PAT_GREEN1 : PAT_GREEN2;
        end else begin
          acount_d = acount_q - CNT_W'(1);
        end
      end else begin
        atick_d = t[TICK_W-1:0];
      end
    end else begin
      // button leaves a wait step
      if (mstep_d[0] && advance_button_i) begin
        mstep_d  = mstep_d + 2'd1;
        lamp_d   = (mstep_d == MSTEP_COUNT2) ? PAT_GREEN2 : PAT_GREEN1;
        mcount_d = cap99(cfg_i.manual_start);
        mtick_d  = '0;
      end
      res_o.lamps = lamp_d;
      if (!mstep_d[0]) begin
        // manual countdown
        res_o.count      = mcount_d;
        res_o.display_on = 1'b1;
        t = {1'b0, mtick_d} + (TICK_W+1)'(1);
        if (t >= {1'b0, limit}) begin
          mtick_d = '0;
          if (mcount_d == '0) begin
            mstep_d = mstep_d + 2'd1;
            lamp_d  = (mstep_d == MSTEP_WAIT1) ? PAT_AMBER1 : PAT_AMBER2;
          end else begin
            mcount_d = mcount_d - CNT_W'(1);
          end
        end else begin
          mtick_d = t[TICK_W-1:0];
        end
      end
    end
    res_o.manual_active = manual_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      manual_q <= 1'b0;
      phase_q  <= 1'b0;
      acount_q <= RST_FIRST_START;
      atick_q  <= '0;
      lamp_q   <= PAT_GREEN1;
      mstep_q  <= MSTEP_COUNT1;
      mcount_q <= RST_MANUAL_START;
      mtick_q  <= '0;
    end else if (advance_i) begin
      manual_q <= manual_d;
      phase_q  <= phase_d;
      acount_q <= acount_d;
      atick_q  <= atick_d;
      lamp_q   <= lamp_d;
      mstep_q  <= mstep_d;
      mcount_q <= mcount_d;
      mtick_q  <= mtick_d;
    end
  end

endmodule

`default_nettype wire

[rtl/tls_out_stage.sv]
// ----------------------------------------------------------------------------
// tls output stage
// Splits the shown count into digits and holds the display word.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_out_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  tls_pkg::tls_res_t         res_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [tls_pkg::LAMP_W-1:0]  lamps_o,
  output logic [tls_pkg::DIGIT_W-1:0] tens_o,
  output logic [tls_pkg::DIGIT_W-1:0] units_o,
  output logic                      display_on_o,
  output logic                      manual_active_o
);
  import tls_pkg::*;

  logic               valid_q, valid_d;
  logic [DIGIT_W-1:0] tens_d, units_d;
  logic [CNT_W-1:0]   tens_x10;
  logic [LAMP_W-1:0]  lamps_q;
  logic [DIGIT_W-1:0] tens_q, units_q;
  logic               on_q, manual_q;

  // digit split, count is zero while the display is off
  assign tens_d   = tens_of(res_i.count);
  assign tens_x10 = {tens_d, 3'b000} - {2'b00, tens_d, 1'b0} + {2'b00, tens_d, 1'b0}
                    + {2'b00, tens_d, 1'b0};
  assign units_d  = DIGIT_W'(res_i.count - tens_x10);

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lamps_q  <= res_i.lamps;
      tens_q   <= tens_d;
      units_q  <= units_d;
      on_q     <= res_i.display_on;
      manual_q <= res_i.manual_active;
    end
  end

  assign out_valid_o     = valid_q;
  assign lamps_o         = lamps_q;
  assign tens_o          = tens_q;
  assign units_o         = units_q;
  assign display_on_o    = on_q;
  assign manual_active_o = manual_q;

endmodule

`default_nettype wire

[tb/traffic_light_sequencer_core_test.sv]
// ----------------------------------------------------------------------------
// traffic light sequencer core testbench
// Drives refresh-tick words into the sequencer and compares every display word
// against an in-bench model of the auto phases, manual steps and lamp memory.
// A directed walk comes first, then randomized timing settings and tick
// streams, with random gaps on the tick side and random stalls on the display
// side, and a final stretch at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module traffic_light_sequencer_core_test;
  import tls_pkg::*;

  typedef struct packed {
    logic [LAMP_W-1:0]  lamps;
    logic [DIGIT_W-1:0] tens_digit;
    logic [DIGIT_W-1:0] units_digit;
    logic               display_on;
    logic               manual_active;
  } display_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tls_in_if  in_ch ();
  tls_out_if out_ch ();

  traffic_light_sequencer_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mirror of the timing registers
  logic [TICK_W-1:0] set_ticks         = RST_TICKS_PER_COUNT;
  logic [CNT_W-1:0]  set_first_start   = RST_FIRST_START;
  logic [CNT_W-1:0]  set_first_amber   = RST_FIRST_AMBER_AT;
  logic [CNT_W-1:0]  set_second_start  = RST_SECOND_START;
  logic [CNT_W-1:0]  set_second_amber  = RST_SECOND_AMBER_AT;
  logic [CNT_W-1:0]  set_manual_start  = RST_MANUAL_START;

  // mirror of the sequencer state
  logic              man_flag  = 1'b0;
  logic              au_phase  = 1'b0;
  logic [CNT_W-1:0]  au_count  = RST_FIRST_START;
  logic [TICK_W-1:0] au_tick   = '0;
  logic [LAMP_W-1:0] lamp_pat  = PAT_GREEN1;
  logic [1:0]        man_step  = MSTEP_COUNT1;
  logic [CNT_W-1:0]  man_count = RST_MANUAL_START;
  logic [TICK_W-1:0] man_tick  = '0;

  display_word_t pending_words[$];
  int            mismatches = 0;
  bit            idle_en = 1'b1;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
    return (v > COUNT_MAX) ? COUNT_MAX : v;
  endfunction

  function automatic display_word_t make_word(input logic [LAMP_W-1:0] lamps,
                                              input logic [CNT_W-1:0] count,
                                              input logic on);
    display_word_t w;
    w.lamps         = lamps;
    w.tens_digit    = on ? DIGIT_W'(count / 10) : '0;
    w.units_digit   = on ? DIGIT_W'(count % 10) : '0;
    w.display_on    = on;
    w.manual_active = man_flag;
    return w;
  endfunction

  // advance the light state by one refresh tick, return the shown word
  function automatic display_word_t step_light_state(input logic tog, input logic btn);
    display_word_t    w;
    logic [CNT_W-1:0] amber;
    int               lim;
    int               nxt;
    lim = (set_ticks == 0) ? 1 : int'(set_ticks);

    // mode toggle takes effect in its own tick
    if (tog) begin
      man_flag = ~man_flag;
      if (man_flag) begin
        man_step  = MSTEP_COUNT1;
        man_count = clamp_count(set_manual_start);
        man_tick  = '0;
        lamp_pat  = PAT_GREEN1;
      end
    end

    // auto phases
    if (!man_flag) begin
      amber = au_phase ? set_second_amber : set_first_amber;
      if (au_tick == 0 && au_count == amber)
        lamp_pat = au_phase ? PAT_AMBER2 : PAT_AMBER1;
      w = make_word(lamp_pat, au_count, 1'b1);
      nxt = int'(au_tick) + 1;
      if (nxt >= lim) begin
        au_tick = '0;
        if (au_count == 0) begin
          au_phase = ~au_phase;
          au_count = clamp_count(au_phase ? set_second_start : set_first_start);
          lamp_pat = au_phase ? PAT_GREEN2 : PAT_GREEN1;
        end else begin
          au_count = au_count - 1'b1;
        end
      end else begin
        au_tick = TICK_W'(nxt);
      end
      return w;
    end

    // button ends a wait step and starts the next countdown at once
    if (man_step[0] && btn) begin
      man_step  = man_step + 2'd1;
      lamp_pat  = (man_step == MSTEP_COUNT2) ? PAT_GREEN2 : PAT_GREEN1;
      man_count = clamp_count(set_manual_start);
      man_tick  = '0;
    end

    if (man_step[0])
      return make_word(lamp_pat, '0, 1'b0);

    // manual countdown
    w = make_word(lamp_pat, man_count, 1'b1);
    nxt = int'(man_tick) + 1;
    if (nxt >= lim) begin
      man_tick = '0;
      if (man_count == 0) begin
        man_step = man_step + 2'd1;
        lamp_pat = (man_step == MSTEP_WAIT1) ? PAT_AMBER1 : PAT_AMBER2;
      end else begin
        man_count = man_count - 1'b1;
      end
    end else begin
      man_tick = TICK_W'(nxt);
    end
    return w;
  endfunction

  // send one tick word, with an occasional gap before it
  task automatic send_tick(input logic tog, input logic btn);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode_toggle    <= tog;
    in_ch.advance_button <= btn;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_words.push_back(step_light_state(tog, btn));
  endtask

  // stop sending and wait until every display word is back
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // write all six timing registers while the block is idle
  task automatic write_settings(input logic [7:0] tpc, input logic [7:0] s1,
                                input logic [7:0] a1, input logic [7:0] s2,
                                input logic [7:0] a2, input logic [7:0] ms);
    logic [CFG_IDX_W-1:0] idx [6];
    logic [7:0]           val [6];
    int                   i;
    idx = '{CFG_TICKS_PER_COUNT, CFG_FIRST_START, CFG_FIRST_AMBER_AT,
            CFG_SECOND_START, CFG_SECOND_AMBER_AT, CFG_MANUAL_START};
    val = '{tpc, s1, a1, s2, a2, ms};
    drain();
    for (i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      case (idx[i])
        CFG_TICKS_PER_COUNT: set_ticks        = val[i];
        CFG_FIRST_START:     set_first_start  = val[i][CNT_W-1:0];
        CFG_FIRST_AMBER_AT:  set_first_amber  = val[i][CNT_W-1:0];
        CFG_SECOND_START:    set_second_start = val[i][CNT_W-1:0];
        CFG_SECOND_AMBER_AT: set_second_amber = val[i][CNT_W-1:0];
        CFG_MANUAL_START:    set_manual_start = val[i][CNT_W-1:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] draw_start();
    return ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 8)) : 8'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] draw_amber(input logic [7:0] start);
    return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, start))
                                      : 8'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] draw_ticks();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'($urandom_range(1, 3));
    if (r < 8) return 8'($urandom_range(0, 255));
    return (r == 8) ? 8'd0 : 8'd255;
  endfunction

  // display side stalls in bursts
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // compare each display word with the oldest expected one
  always @(posedge clk_i) begin
    display_word_t got;
    display_word_t exp;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.lamps, out_ch.tens_digit, out_ch.units_digit,
              out_ch.display_on, out_ch.manual_active};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected display word: lamps=%h tens=%0d units=%0d on=%0b man=%0b",
                   got.lamps, got.tens_digit, got.units_digit, got.display_on,
                   got.manual_active);
      end else begin
        exp = pending_words.pop_front();
        if (got.lamps != exp.lamps || got.tens_digit != exp.tens_digit ||
            got.units_digit != exp.units_digit || got.display_on != exp.display_on ||
            got.manual_active != exp.manual_active) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp lamps=%h tens=%0d units=%0d on=%0b man=%0b, got lamps=%h tens=%0d units=%0d on=%0b man=%0b",
                     exp.lamps, exp.tens_digit, exp.units_digit, exp.display_on,
                     exp.manual_active, got.lamps, got.tens_digit, got.units_digit,
                     got.display_on, got.manual_active);
        end
      end
    end
  end

  // auto walk from reset: amber switch, zero tick length, capped start,
  // amber that is never reached
  task automatic test_auto_walk;
    int i;
    write_settings(8'd0, 8'd2, 8'd20, 8'd127, 8'd127, 8'd1);
    for (i = 0; i < 25; i++) send_tick(1'b0, 1'b0);
  endtask

  // manual sequence: button ignored during countdown, both waits,
  // toggle with button back to auto keeping the manual lamps
  task automatic test_manual_walk;
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  // random timing settings, each followed by a stream of tick words
  task automatic test_random_traffic(input int phases, input int per_phase);
    int         p;
    int         n;
    bit         noisy;
    logic       tog;
    logic       btn;
    logic [7:0] s1;
    logic [7:0] s2;
    for (p = 0; p < phases; p++) begin
      if (p == 0) begin
        write_settings(8'd255, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127);
      end else if (p == 1) begin
        write_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      end else begin
        s1 = draw_start();
        s2 = draw_start();
        write_settings(draw_ticks(), s1, draw_amber(s1), s2, draw_amber(s2),
                       ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 4))
                                                  : 8'($urandom_range(0, 127)));
      end
      noisy = ($urandom_range(0, 4) == 0);
      for (n = 0; n < per_phase; n++) begin
        if (noisy) begin
          tog = 1'($urandom_range(0, 1));
          btn = 1'($urandom_range(0, 1));
        end else begin
          tog = ($urandom_range(0, 59) == 0);
          btn = ($urandom_range(0, 2) == 0);
        end
        send_tick(tog, btn);
      end
    end
  endtask

  // full-rate stretch with no gaps and no stalls
  task automatic test_steady_flow(input int count);
    int n;
    drain();
    idle_en = 1'b0;
    write_settings(8'($urandom_range(1, 2)), 8'd6, 8'd3, 8'd4, 8'd2, 8'd2);
    for (n = 0; n < count; n++)
      send_tick($urandom_range(0, 39) == 0, $urandom_range(0, 2) == 0);
  endtask

  // sequence of tests
  initial begin
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_TICKS_PER_COUNT;
    cfg_data_i           <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.mode_toggle    <= 1'b0;
    in_ch.advance_button <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_auto_walk();
    test_manual_walk();
    test_random_traffic(11, 150);
    test_steady_flow(150);
    drain();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
